// ===== src/lei_pkg.sv =====
// ============================================================================
// lei_pkg
// Shared types, constants and the micro-program of the Lorenz Euler stepper.
// ============================================================================
`default_nettype none

package lei_pkg;

  localparam int FRAC_BITS = 20;
  localparam int DATA_W    = 32;
  localparam int UFRAC_W   = 20;
  localparam int COUNT_W   = 21;
  localparam int OPND_W    = DATA_W + 1;
  localparam int PROD_W    = 2 * OPND_W;
  localparam int NUM_UOPS  = 12;
  localparam int OP_W      = $clog2(NUM_UOPS);
  localparam int INDEX_W   = 3;

  localparam logic signed [DATA_W-1:0] POS_RESET = -32'sd1048576;
  localparam logic signed [OPND_W-1:0] ONE_Q     = OPND_W'(1) <<< FRAC_BITS;

  localparam logic signed [DATA_W-1:0]  SIGMA_RESET        = 32'sd10485760;
  localparam logic signed [DATA_W-1:0]  BETA_RESET         = 32'sd2726298;
  localparam logic signed [DATA_W-1:0]  RHO_RESET          = 32'sd52428800;
  localparam logic        [UFRAC_W-1:0] TIME_STEP_RESET    = 20'd5243;
  localparam logic        [UFRAC_W-1:0] OUTPUT_SCALE_RESET = 20'd41943;
  localparam logic        [COUNT_W-1:0] RUN_LENGTH_RESET   = 21'd70000;

  typedef enum logic [INDEX_W-1:0] {
    REG_SIGMA        = 3'd0,
    REG_BETA         = 3'd1,
    REG_RHO          = 3'd2,
    REG_TIME_STEP    = 3'd3,
    REG_OUTPUT_SCALE = 3'd4,
    REG_RUN_LENGTH   = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  sigma;
    logic signed [DATA_W-1:0]  beta;
    logic signed [DATA_W-1:0]  rho;
    logic        [UFRAC_W-1:0] time_step;
    logic        [UFRAC_W-1:0] output_scale;
    logic        [COUNT_W-1:0] run_length;
  } cfg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] z;
    logic                     last;
  } res_t;

  typedef enum logic [3:0] {
    SRC_X     = 4'd0,
    SRC_Y     = 4'd1,
    SRC_Z     = 4'd2,
    SRC_ONE   = 4'd3,
    SRC_SIGMA = 4'd4,
    SRC_BETA  = 4'd5,
    SRC_RHO   = 4'd6,
    SRC_DT    = 4'd7,
    SRC_SCALE = 4'd8,
    SRC_T     = 4'd9,
    SRC_D0    = 4'd10,
    SRC_D1    = 4'd11,
    SRC_D2    = 4'd12
  } src_t;

  // pass: q; add: addend + q; sub_q: addend - q; sub_a: q - addend
  typedef enum logic [1:0] {
    MODE_PASS  = 2'd0,
    MODE_ADD   = 2'd1,
    MODE_SUB_Q = 2'd2,
    MODE_SUB_A = 2'd3
  } alu_mode_t;

  typedef enum logic [2:0] {
    DST_T  = 3'd0,
    DST_D0 = 3'd1,
    DST_D1 = 3'd2,
    DST_D2 = 3'd3,
    DST_X  = 3'd4,
    DST_Y  = 3'd5,
    DST_Z  = 3'd6
  } dst_t;

  typedef struct packed {
    src_t      src_a;
    src_t      src_b;
    src_t      src_add;
    alu_mode_t mode;
    dst_t      dst;
  } uop_t;

  // one euler step: differences, derivatives, new point, scaled output
  function automatic uop_t uop_rom(input logic [OP_W-1:0] idx);
    uop_t u;
    u = '{SRC_X, SRC_ONE, SRC_T, MODE_PASS, DST_T};
    unique case (idx)
      4'd0:    u = '{SRC_X,     SRC_ONE, SRC_Y,   MODE_SUB_Q, DST_T};
      4'd1:    u = '{SRC_SIGMA, SRC_T,   SRC_T,   MODE_PASS,  DST_D0};
      4'd2:    u = '{SRC_Z,     SRC_ONE, SRC_RHO, MODE_SUB_Q, DST_T};
      4'd3:    u = '{SRC_X,     SRC_T,   SRC_Y,   MODE_SUB_A, DST_D1};
      4'd4:    u = '{SRC_X,     SRC_Y,   SRC_T,   MODE_PASS,  DST_T};
      4'd5:    u = '{SRC_BETA,  SRC_Z,   SRC_T,   MODE_SUB_Q, DST_D2};
      4'd6:    u = '{SRC_DT,    SRC_D0,  SRC_X,   MODE_ADD,   DST_X};
      4'd7:    u = '{SRC_DT,    SRC_D1,  SRC_Y,   MODE_ADD,   DST_Y};
      4'd8:    u = '{SRC_DT,    SRC_D2,  SRC_Z,   MODE_ADD,   DST_Z};
      4'd9:    u = '{SRC_SCALE, SRC_X,   SRC_T,   MODE_PASS,  DST_D0};
      4'd10:   u = '{SRC_SCALE, SRC_Y,   SRC_T,   MODE_PASS,  DST_D1};
      4'd11:   u = '{SRC_SCALE, SRC_Z,   SRC_T,   MODE_PASS,  DST_D2};
      default: u = '{SRC_X,     SRC_ONE, SRC_T,   MODE_PASS,  DST_T};
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

// ===== src/lei_alu.sv =====
// ============================================================================
// lei_alu
// Shared multiply unit: registered product, floor shift, saturate, add.
// ============================================================================
`default_nettype none

module lei_alu (
  input  wire                                clk,
  input  wire                                load,
  input  wire logic signed [lei_pkg::OPND_W-1:0] op_a,
  input  wire logic signed [lei_pkg::OPND_W-1:0] op_b,
  input  wire lei_pkg::alu_mode_t            mode,
  input  wire logic signed [lei_pkg::DATA_W-1:0] addend,
  output logic signed [lei_pkg::DATA_W-1:0]  result
);
  import lei_pkg::*;

  localparam int SUM_W = DATA_W + 2;

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] shifted;
  logic signed [DATA_W-1:0] q;
  logic signed [SUM_W-1:0]  q_ext;
  logic signed [SUM_W-1:0]  a_ext;
  logic signed [SUM_W-1:0]  sum;

  localparam logic signed [DATA_W-1:0] S_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] S_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // operands widened first so the full product is kept
  always_ff @(posedge clk) begin
    if (load) begin
      prod <= PROD_W'(op_a) * PROD_W'(op_b);
    end
  end

  // arithmetic shift gives rounding toward minus infinity
  always_comb begin
    shifted = prod >>> FRAC_BITS;
    if (shifted > PROD_W'(S_MAX)) begin
      q = S_MAX;
    end else if (shifted < PROD_W'(S_MIN)) begin
      q = S_MIN;
    end else begin
      q = shifted[DATA_W-1:0];
    end
  end

  always_comb begin
    q_ext = SUM_W'(q);
    a_ext = SUM_W'(addend);
    unique case (mode)
      MODE_PASS:  sum = q_ext;
      MODE_ADD:   sum = a_ext + q_ext;
      MODE_SUB_Q: sum = a_ext - q_ext;
      MODE_SUB_A: sum = q_ext - a_ext;
      default:    sum = q_ext;
    endcase
    if ((sum[SUM_W-1:DATA_W-1] != '0) && (sum[SUM_W-1:DATA_W-1] != '1)) begin
      result = sum[SUM_W-1] ? S_MIN : S_MAX;
    end else begin
      result = sum[DATA_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== src/lei_seq.sv =====
// ============================================================================
// lei_seq
// Sequencer and state registers: runs the micro-program through the alu.
// ============================================================================
`default_nettype none

module lei_seq (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  input  wire                 out_free,
  input  wire lei_pkg::cfg_t  cfg,
  output logic                idle,
  output logic                res_valid,
  output lei_pkg::res_t       res
);
  import lei_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_WRITE = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic [OP_W-1:0] op;
  uop_t uop;

  logic signed [DATA_W-1:0] pos_x, pos_y, pos_z;
  logic signed [DATA_W-1:0] t_reg, d0, d1, d2;
  logic [COUNT_W-1:0] step_count;

  logic signed [OPND_W-1:0] op_a, op_b, add_full;
  logic signed [DATA_W-1:0] alu_result;
  logic last;

  function automatic logic signed [OPND_W-1:0] sel(
    input src_t s,
    input logic signed [DATA_W-1:0] x, y, z, t, e0, e1, e2,
    input cfg_t c
  );
    logic signed [OPND_W-1:0] v;
    unique case (s)
      SRC_X:     v = OPND_W'(x);
      SRC_Y:     v = OPND_W'(y);
      SRC_Z:     v = OPND_W'(z);
      SRC_ONE:   v = ONE_Q;
      SRC_SIGMA: v = OPND_W'(c.sigma);
      SRC_BETA:  v = OPND_W'(c.beta);
      SRC_RHO:   v = OPND_W'(c.rho);
      SRC_DT:    v = OPND_W'({1'b0, c.time_step});
      SRC_SCALE: v = OPND_W'({1'b0, c.output_scale});
      SRC_T:     v = OPND_W'(t);
      SRC_D0:    v = OPND_W'(e0);
      SRC_D1:    v = OPND_W'(e1);
      SRC_D2:    v = OPND_W'(e2);
      default:   v = '0;
    endcase
    return v;
  endfunction

  assign uop      = uop_rom(op);
  assign op_a     = sel(uop.src_a, pos_x, pos_y, pos_z, t_reg, d0, d1, d2, cfg);
  assign op_b     = sel(uop.src_b, pos_x, pos_y, pos_z, t_reg, d0, d1, d2, cfg);
  assign add_full = sel(uop.src_add, pos_x, pos_y, pos_z, t_reg, d0, d1, d2, cfg);

  lei_alu u_alu (
    .clk    (clk),
    .load   (state == ST_ISSUE),
    .op_a   (op_a),
    .op_b   (op_b),
    .mode   (uop.mode),
    .addend (add_full[DATA_W-1:0]),
    .result (alu_result)
  );

  // zero run length compares as one, so every step ends a run
  assign last = ({1'b0, step_count} + (COUNT_W+1)'(1)) >= {1'b0, cfg.run_length};

  assign idle      = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE) && out_free;
  assign res       = '{x: d0, y: d1, z: d2, last: last};

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (start) state_next = ST_ISSUE;
      ST_ISSUE: state_next = ST_WRITE;
      ST_WRITE: begin
        if (op == OP_W'(NUM_UOPS - 1)) state_next = ST_DONE;
        else state_next = ST_ISSUE;
      end
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      op         <= '0;
      pos_x      <= POS_RESET;
      pos_y      <= POS_RESET;
      pos_z      <= POS_RESET;
      step_count <= '0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE) begin
        op <= '0;
      end else if ((state == ST_WRITE) && (op != OP_W'(NUM_UOPS - 1))) begin
        op <= op + OP_W'(1);
      end
      if (state == ST_WRITE) begin
        unique case (uop.dst)
          DST_X:   pos_x <= alu_result;
          DST_Y:   pos_y <= alu_result;
          DST_Z:   pos_z <= alu_result;
          default: ;
        endcase
      end
      if (res_valid) begin
        if (last) begin
          pos_x      <= POS_RESET;
          pos_y      <= POS_RESET;
          pos_z      <= POS_RESET;
          step_count <= '0;
        end else begin
          step_count <= step_count + COUNT_W'(1);
        end
      end
    end
  end

  // scratch registers
  always_ff @(posedge clk) begin
    if (state == ST_WRITE) begin
      unique case (uop.dst)
        DST_T:   t_reg <= alu_result;
        DST_D0:  d0    <= alu_result;
        DST_D1:  d1    <= alu_result;
        DST_D2:  d2    <= alu_result;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/lorenz_euler_integrator_top.sv =====
// ============================================================================
// lorenz_euler_integrator_top
// Fixed-point Lorenz system stepper, one explicit Euler step per tick item with tick high.
// ============================================================================
// Each accepted tick item with tick high advances the point (x, y, z) by one
// Euler step of the Lorenz equations in signed Q12.20 and returns the new
// point times output_scale, with last_of_run set on the final step of a run;
// after that step the point restarts at (-1, -1, -1). A tick item with tick
// low is taken and produces no result. All twelve multiplications of a step
// (including the differences, which go through the unit as a product by one)
// run on one shared 33x33 multiplier with a registered product, each passing
// through an issue state and a write-back state, so after acceptance a step
// holds in_stall high through all its micro-ops and the hand-off state, longer
// if the output register is still waiting on out_stall. The result sits in an
// output register, so the next tick can be accepted while it waits.
// Configuration writes are always ready and should only be issued while idle.
// ============================================================================
`default_nettype none

module lorenz_euler_integrator_top (
  input  wire                               clk,
  input  wire                               rst,
  // tick item channel
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire                               tick,
  // result item channel
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic signed [lei_pkg::DATA_W-1:0] x_out,
  output logic signed [lei_pkg::DATA_W-1:0] y_out,
  output logic signed [lei_pkg::DATA_W-1:0] z_out,
  output logic                              last_of_run,
  // configuration write channel
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire  [lei_pkg::INDEX_W-1:0]       cfg_index,
  input  wire  [lei_pkg::DATA_W-1:0]        cfg_data
);
  import lei_pkg::*;

  cfg_t cfg;
  res_t res;
  logic idle;
  logic res_valid;
  logic out_free;
  logic start;

  // register file, writes outside the list are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sigma        <= SIGMA_RESET;
      cfg.beta         <= BETA_RESET;
      cfg.rho          <= RHO_RESET;
      cfg.time_step    <= TIME_STEP_RESET;
      cfg.output_scale <= OUTPUT_SCALE_RESET;
      cfg.run_length   <= RUN_LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SIGMA:        cfg.sigma        <= cfg_data;
        REG_BETA:         cfg.beta         <= cfg_data;
        REG_RHO:          cfg.rho          <= cfg_data;
        REG_TIME_STEP:    cfg.time_step    <= cfg_data[UFRAC_W-1:0];
        REG_OUTPUT_SCALE: cfg.output_scale <= cfg_data[UFRAC_W-1:0];
        REG_RUN_LENGTH:   cfg.run_length   <= cfg_data[COUNT_W-1:0];
        default:          ;
      endcase
    end
  end

  // tick items are taken only when the sequencer is idle
  assign in_stall = !idle;
  assign start    = in_valid && !in_stall && tick;

  // output register frees up in the same cycle it is taken
  assign out_free = !out_valid || !out_stall;

  lei_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .out_free  (out_free),
    .cfg       (cfg),
    .idle      (idle),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (res_valid) begin
      x_out       <= res.x;
      y_out       <= res.y;
      z_out       <= res.z;
      last_of_run <= res.last;
    end
  end

endmodule

`default_nettype wire

// ===== sim/tb_lorenz_euler_integrator_top.sv =====
// ============================================================================
// tb_lorenz_euler_integrator_top
// Self-checking bench for the fixed-point Lorenz Euler stepper.
// ============================================================================
// Tick items go in and scaled points come out. A bit-exact predictor in a
// small tracker class follows every accepted tick: the point, the step count
// and the coefficient registers. Each result is checked field by field
// against the oldest predicted point. A short directed part covers the
// defaults, idle ticks, lowering the run length in the middle of a run, a zero
// run length, saturating coefficient extremes and writes to unused register
// indexes. After that come random coefficient settings, half of them
// plausible and the rest raw or extreme, with random gaps on both channels and
// long output hold-offs.
// ============================================================================

module tb_lorenz_euler_integrator_top;
  import lei_pkg::*;

  localparam int NUM_REGS   = 6;
  localparam int WANT_STEPS = 450;
  localparam int MAX_GAP    = 12;
  localparam int SETTLE_CYC = 40;   // covers a full step, plus margin
  localparam int LONG_HOLD  = 250;

  // predicts every result and keeps the results that are still due
  class lorenz_tracker;
    localparam longint S32_TOP = 64'sd2147483647;
    localparam longint S32_BOT = -64'sd2147483648;

    cfg_t                     regs;
    logic signed [DATA_W-1:0] pos_x, pos_y, pos_z;
    logic [COUNT_W-1:0]       step_count;
    res_t                     points_due[$];
    int                       errors, checked, run_ends, idle_ticks, steps_taken;

    function new();
      regs = '{SIGMA_RESET, BETA_RESET, RHO_RESET, TIME_STEP_RESET,
               OUTPUT_SCALE_RESET, RUN_LENGTH_RESET};
      restart();
    endfunction

    function void restart();
      pos_x      = POS_RESET;
      pos_y      = POS_RESET;
      pos_z      = POS_RESET;
      step_count = '0;
    endfunction

    function void set_reg(logic [INDEX_W-1:0] idx, logic [DATA_W-1:0] data);
      unique case (idx)
        REG_SIGMA:        regs.sigma        = data;
        REG_BETA:         regs.beta         = data;
        REG_RHO:          regs.rho          = data;
        REG_TIME_STEP:    regs.time_step    = data[UFRAC_W-1:0];
        REG_OUTPUT_SCALE: regs.output_scale = data[UFRAC_W-1:0];
        REG_RUN_LENGTH:   regs.run_length   = data[COUNT_W-1:0];
        default: ;
      endcase
    endfunction

    function longint clamp32(longint v);
      if (v > S32_TOP) return S32_TOP;
      if (v < S32_BOT) return S32_BOT;
      return v;
    endfunction

    // exact product, floor shift, saturate
    function longint qprod(longint a, longint b);
      return clamp32((a * b) >>> FRAC_BITS);
    endfunction

    function void note_tick(logic t);
      longint s, b, r, dt, sc, px, py, pz;
      longint dx, dy, dz, nx, ny, nz;
      res_t   due;
      if (!t) begin
        idle_ticks++;
        return;
      end
      s  = longint'(regs.sigma);
      b  = longint'(regs.beta);
      r  = longint'(regs.rho);
      dt = longint'(regs.time_step);
      sc = longint'(regs.output_scale);
      px = longint'(pos_x);
      py = longint'(pos_y);
      pz = longint'(pos_z);
      dx = qprod(s, clamp32(py - px));
      dy = clamp32(qprod(px, clamp32(r - pz)) - py);
      dz = clamp32(qprod(px, py) - qprod(b, pz));
      nx = clamp32(px + qprod(dt, dx));
      ny = clamp32(py + qprod(dt, dy));
      nz = clamp32(pz + qprod(dt, dz));
      due.x    = DATA_W'(qprod(sc, nx));
      due.y    = DATA_W'(qprod(sc, ny));
      due.z    = DATA_W'(qprod(sc, nz));
      due.last = (int'(step_count) + 1) >= int'(regs.run_length);
      points_due.push_back(due);
      steps_taken++;
      if (due.last) begin
        restart();
      end else begin
        pos_x      = DATA_W'(nx);
        pos_y      = DATA_W'(ny);
        pos_z      = DATA_W'(nz);
        step_count = step_count + 1'b1;
      end
    endfunction

    task report(string what);
      errors++;
      $display("mismatch: %s", what);
    endtask

    task check_result(res_t got);
      res_t want;
      if (points_due.size() == 0) begin
        report($sformatf("result with nothing due x=%0d y=%0d z=%0d last=%0b",
                         got.x, got.y, got.z, got.last));
        return;
      end
      want = points_due.pop_front();
      if (got.x !== want.x)
        report($sformatf("point %0d x_out %0d, want %0d", checked, got.x, want.x));
      if (got.y !== want.y)
        report($sformatf("point %0d y_out %0d, want %0d", checked, got.y, want.y));
      if (got.z !== want.z)
        report($sformatf("point %0d z_out %0d, want %0d", checked, got.z, want.z));
      if (got.last !== want.last)
        report($sformatf("point %0d last_of_run %0b, want %0b", checked, got.last,
                         want.last));
      checked++;
      if (want.last) run_ends++;
    endtask

    task flush();
      while (points_due.size() != 0) begin
        report("predicted point never came out");
        void'(points_due.pop_front());
      end
    endtask
  endclass

  logic                     clk, rst;
  logic                     in_valid, in_stall, tick;
  logic                     out_valid, out_stall, last_of_run;
  logic signed [DATA_W-1:0] x_out, y_out, z_out;
  logic                     cfg_valid, cfg_ready;
  logic [INDEX_W-1:0]       cfg_index;
  logic [DATA_W-1:0]        cfg_data;

  lorenz_tracker tracker = new();

  // idling knobs, one for each side, and the long hold-off request
  int tx_gap_max, rx_gap_max, hold_request;
  int long_holds, reg_writes, settings;

  lorenz_euler_integrator_top dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .tick        (tick),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .x_out       (x_out),
    .y_out       (y_out),
    .z_out       (z_out),
    .last_of_run (last_of_run),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #3000000;
    $display("timeout: results still due %0d", tracker.points_due.size());
    $display("== FAIL ==");
    $finish;
  end

  // result side: random stall before each item, long hold-off on request
  initial begin : result_sink
    int   stall_cyc;
    res_t got;
    out_stall = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_request > 0) begin
        stall_cyc    = hold_request;
        hold_request = 0;
        long_holds++;
      end else begin
        stall_cyc = $urandom_range(0, rx_gap_max);
      end
      // the hold-off counts its own cycles here, independent of the sender
      repeat (stall_cyc) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      got = '{x_out, y_out, z_out, last_of_run};
      tracker.check_result(got);
    end
  end

  // offer one tick item after a gap; valid stays up until it is taken
  task automatic offer_tick(logic t, int gap);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    tick     <= t;
    do @(posedge clk); while (in_stall);
    tracker.note_tick(t);
  endtask

  task automatic send_burst(int count, int idle_pct);
    for (int i = 0; i < count; i++)
      offer_tick($urandom_range(0, 99) >= idle_pct, $urandom_range(0, tx_gap_max));
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic send_fixed(logic t, int count);
    for (int i = 0; i < count; i++)
      offer_tick(t, 0);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // sender pauses until every predicted point is out, then lets an idle tick
  // still in flight finish before any register changes
  task automatic wait_for_results();
    while (tracker.points_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(logic [INDEX_W-1:0] idx, logic [DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_reg(idx, data);
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // saturation corners, also giving run lengths of 0, 2^20 and all ones
  function automatic logic [DATA_W-1:0] extreme_word(int pick);
    unique case (pick)
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return 32'h0010_0000;
    endcase
  endfunction

  task automatic pick_setting(int kind);
    settings++;
    unique case (kind)
      0, 1: begin
        // near the classic attractor, short runs so restarts are frequent
        write_reg(REG_SIGMA, int'(SIGMA_RESET) + int'($urandom_range(0, 4194304)) - 2097152);
        write_reg(REG_BETA, int'(BETA_RESET) + int'($urandom_range(0, 2097152)) - 1048576);
        write_reg(REG_RHO, $urandom_range(0, 60) << FRAC_BITS);
        // upper bits of the narrow registers are junk and must be dropped
        write_reg(REG_TIME_STEP, $urandom_range(1, 20000) | ($urandom & 32'hFFF0_0000));
        write_reg(REG_OUTPUT_SCALE, $urandom);
        write_reg(REG_RUN_LENGTH, $urandom_range(1, 50) | ($urandom & 32'hFFE0_0000));
      end
      2: begin
        for (int i = 0; i < NUM_REGS; i++)
          if ($urandom_range(0, 9) < 7) write_reg(INDEX_W'(i), $urandom);
      end
      default: begin
        for (int i = 0; i < NUM_REGS; i++)
          write_reg(INDEX_W'(i), extreme_word($urandom_range(0, 4)));
      end
    endcase
    // writes past the register list must leave everything alone
    if ($urandom_range(0, 3) == 0)
      write_reg(INDEX_W'(NUM_REGS + $urandom_range(0, 1)), $urandom);
  endtask

  initial begin : stimulus
    int phase;
    rst          = 1'b1;
    in_valid     = 1'b0;
    tick         = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    tx_gap_max   = 0;
    rx_gap_max   = 0;
    hold_request = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // defaults out of reset, with an idle tick in the middle
    settings++;
    offer_tick(1'b1, 0);
    offer_tick(1'b1, 0);
    offer_tick(1'b0, 0);
    send_fixed(1'b1, 2);
    wait_for_results();

    // run length dropped below the current step count: next step ends the run
    settings++;
    write_reg(REG_RUN_LENGTH, 32'd3);
    send_fixed(1'b1, 4);
    wait_for_results();

    // zero run length acts like one, junk above bit 20 is ignored
    settings++;
    write_reg(REG_RUN_LENGTH, 32'hFFE0_0000);
    send_fixed(1'b1, 2);
    wait_for_results();

    // coefficients at the extremes drive every stage into saturation
    settings++;
    write_reg(REG_SIGMA, 32'h7FFF_FFFF);
    write_reg(REG_BETA, 32'h8000_0000);
    write_reg(REG_RHO, 32'h8000_0000);
    write_reg(REG_TIME_STEP, 32'hFFFF_FFFF);
    write_reg(REG_OUTPUT_SCALE, 32'hFFFF_FFFF);
    write_reg(REG_RUN_LENGTH, 32'd4);
    send_fixed(1'b1, 4);
    wait_for_results();

    // opposite corners, zero time step and zero scale, longest run length
    settings++;
    write_reg(REG_SIGMA, 32'h8000_0000);
    write_reg(REG_BETA, 32'h7FFF_FFFF);
    write_reg(REG_RHO, 32'h7FFF_FFFF);
    write_reg(REG_TIME_STEP, 32'h0000_0000);
    write_reg(REG_OUTPUT_SCALE, 32'h0000_0000);
    write_reg(REG_RUN_LENGTH, 32'h001F_FFFF);
    send_fixed(1'b1, 2);
    wait_for_results();

    // unused indexes
    write_reg(INDEX_W'(NUM_REGS), $urandom);
    write_reg(INDEX_W'(NUM_REGS + 1), $urandom);
    send_fixed(1'b1, 2);

    // random part: new setting per phase, random idling on both sides
    phase = 0;
    while (tracker.steps_taken < WANT_STEPS) begin
      wait_for_results();
      pick_setting($urandom_range(0, 3));
      tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
      rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
      if (phase == 2 || phase == 9) begin
        // output held off for a long stretch while ticks keep coming:
        // the output register and the step behind it fill, in_stall rises
        hold_request = LONG_HOLD;
        tx_gap_max   = 0;
        send_burst(12, 0);
      end else begin
        send_burst($urandom_range(10, 40), 8);
      end
      phase++;
    end

    wait_for_results();
    tracker.flush();
    $display("covered %0d steps and %0d ignored ticks over %0d coefficient settings",
             tracker.checked, tracker.idle_ticks, settings);
    $display("%0d run ends, %0d register writes, %0d long output hold-offs, %0d errors",
             tracker.run_ends, reg_writes, long_holds, tracker.errors);
    if (tracker.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== lorenz_euler_integrator_top.f =====
src/lei_pkg.sv
src/lei_alu.sv
src/lei_seq.sv
src/lorenz_euler_integrator_top.sv
sim/tb_lorenz_euler_integrator_top.sv
